[rtl/pafs_pkg.sv]
package pafs_pkg;

  localparam logic OP_BEGIN  = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_FAN   = 2'd1;
  localparam logic [1:0] MODE_STRIP = 2'd2;

  // Vertex phase: first, second, later with even count, later with odd count
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_EVEN   = 2'd2;
  localparam logic [1:0] PH_ODD    = 2'd3;

  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
  } vtx_t;

  typedef struct packed {
    vtx_t c0;
    vtx_t c1;
    vtx_t c2;
  } tri_t;

  // Handshake between queue and back end
  typedef struct packed {
    logic valid;
    tri_t data;
  } tri_req_t;

endpackage

[rtl/pafs_front.sv]
module pafs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          op_i,
  input  logic [1:0]    prim_mode_i,
  input  pafs_pkg::vtx_t vtx_i,
  output logic          tri_valid_o,
  output pafs_pkg::tri_t tri_o
);
  import pafs_pkg::*;

  logic [1:0] kind_q, kind_d;
  logic [1:0] phase_q, phase_d;
  vtx_t       slot0_q, slot0_d;
  vtx_t       slot1_q, slot1_d;
  logic       active;
  logic       swap;

  assign active = (kind_q == MODE_FAN) || (kind_q == MODE_STRIP);
  assign swap   = (kind_q == MODE_STRIP) && (phase_q == PH_ODD);

  always_comb begin
    kind_d      = kind_q;
    phase_d     = phase_q;
    slot0_d     = slot0_q;
    slot1_d     = slot1_q;
    tri_valid_o = 1'b0;
    tri_o.c0    = swap ? slot1_q : slot0_q;
    tri_o.c1    = swap ? slot0_q : slot1_q;
    tri_o.c2    = vtx_i;
    if (accept_i) begin
      if (op_i == OP_BEGIN) begin
        kind_d  = ((prim_mode_i == MODE_FAN) || (prim_mode_i == MODE_STRIP)) ?
                  prim_mode_i : MODE_NONE;
        phase_d = PH_FIRST;
      end else begin
        if (active) begin
          case (phase_q)
            PH_FIRST:  slot0_d = vtx_i;
            PH_SECOND: slot1_d = vtx_i;
            default: begin
              tri_valid_o = 1'b1;
              if (kind_q == MODE_STRIP) slot0_d = slot1_q;
              slot1_d = vtx_i;
            end
          endcase
        end
        phase_d = (phase_q == PH_ODD) ? PH_EVEN : phase_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= MODE_NONE;
      phase_q <= PH_FIRST;
    end else begin
      kind_q  <= kind_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

[rtl/pafs_queue.sv]
module pafs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  pafs_pkg::tri_t     wr_data_i,
  output logic               full_o,
  input  logic               rd_i,
  output pafs_pkg::tri_req_t rd_o
);
  import pafs_pkg::*;

  tri_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_wr, do_rd;

  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign rd_o.valid = (cnt_q != '0);
  assign rd_o.data  = mem_q[rptr_q];
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && rd_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= wptr_q + QPTR_W'(1);
      if (do_rd) rptr_q <= rptr_q + QPTR_W'(1);
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wr_data_i;
  end

endmodule

[rtl/pafs_back.sv]
module pafs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pafs_pkg::tri_req_t req_i,
  output logic               take_o,
  output logic               empty_o,
  input  logic               pop_i,
  output pafs_pkg::vtx_t     vtx_o,
  output logic [1:0]         corner_o
);
  import pafs_pkg::*;

  tri_t       tri_q;
  logic       busy_q;
  logic [1:0] corner_q;
  logic       advance;

  assign advance = !busy_q || (pop_i && (corner_q == CORNER_2));
  assign take_o  = advance && req_i.valid;
  assign empty_o = !busy_q;
  assign corner_o = corner_q;

  always_comb begin
    case (corner_q)
      CORNER_0: vtx_o = tri_q.c0;
      CORNER_1: vtx_o = tri_q.c1;
      default:  vtx_o = tri_q.c2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      corner_q <= CORNER_0;
    end else if (advance) begin
      busy_q   <= req_i.valid;
      corner_q <= CORNER_0;
    end else if (pop_i) begin
      corner_q <= corner_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) tri_q <= req_i.data;
  end

endmodule

[rtl/primitive_assembler_fan_strip.sv]
// With the back end idle, a vertex that closes a triangle is written into the triangle queue and
// then loaded into the back end's triangle register, which puts its first corner on the result ports.
// Throughput: one item per cycle in while full is low; one corner per cycle out while pop is held;
// each emitting vertex gives three corners; a two-deep triangle queue decouples front and back.
// Reset: rst_ni clears mode to none, vertex phase, queue pointers and the output stage.
// Saved vertex slots and queue storage are not reset; they are written before they are read.
module primitive_assembler_fan_strip (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        op_i,
  input  logic [1:0]  prim_mode_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] norm_x_i,
  input  logic [31:0] norm_y_i,
  input  logic [31:0] norm_z_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_pos_x_o,
  output logic [31:0] out_pos_y_o,
  output logic [31:0] out_pos_z_o,
  output logic [31:0] out_norm_x_o,
  output logic [31:0] out_norm_y_o,
  output logic [31:0] out_norm_z_o,
  output logic [1:0]  corner_o,
  output logic        last_corner_o
);
  import pafs_pkg::*;

  vtx_t     vtx_in;
  vtx_t     vtx_out;
  logic     accept;
  logic     tri_valid;
  tri_t     tri_new;
  tri_req_t tri_req;
  logic     tri_take;

  // Gather the vertex words into one record
  assign vtx_in.pos_x  = pos_x_i;
  assign vtx_in.pos_y  = pos_y_i;
  assign vtx_in.pos_z  = pos_z_i;
  assign vtx_in.norm_x = norm_x_i;
  assign vtx_in.norm_y = norm_y_i;
  assign vtx_in.norm_z = norm_z_i;

  // Hold off input whenever the triangle queue has no room for a transaction
  assign accept = push && !full;

  // Front end: track mode and phase, keep the anchor/older and previous vertices,
  // and build each triangle with its corners already in output order.
  pafs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op_i),
    .prim_mode_i (prim_mode_i),
    .vtx_i       (vtx_in),
    .tri_valid_o (tri_valid),
    .tri_o       (tri_new)
  );

  // Short queue of whole triangles between front and back
  pafs_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tri_valid),
    .wr_data_i (tri_new),
    .full_o    (full),
    .rd_i      (tri_take),
    .rd_o      (tri_req)
  );

  // Back end: advance through the three corners, one per popped transaction
  pafs_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (tri_req),
    .take_o   (tri_take),
    .empty_o  (empty),
    .pop_i    (pop),
    .vtx_o    (vtx_out),
    .corner_o (corner_o)
  );

  assign out_pos_x_o   = vtx_out.pos_x;
  assign out_pos_y_o   = vtx_out.pos_y;
  assign out_pos_z_o   = vtx_out.pos_z;
  assign out_norm_x_o  = vtx_out.norm_x;
  assign out_norm_y_o  = vtx_out.norm_y;
  assign out_norm_z_o  = vtx_out.norm_z;
  assign last_corner_o = (corner_o == CORNER_2);

endmodule
